FILE: rtl/core/rpg_pkg.sv
// Shared types and constants of the random permutation generator.
// No dependencies; compiled first.
package rpg_pkg;

    localparam int RAND_W = 31;
    localparam int PICK_W = 6;
    localparam int LEN_W  = 7;
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_PICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/core/rpg_if.sv
// Valid/ready channels of the random permutation generator.
// Depends on rpg_pkg for the field widths.
interface rpg_in_if;
    logic                              valid;
    logic                              ready;
    logic [rpg_pkg::RAND_W-1:0]        random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface rpg_out_if;
    logic                              valid;
    logic                              ready;
    logic [rpg_pkg::PICK_W-1:0]        picked_value;
    logic                              last_of_perm;

    modport source (output valid, output picked_value, output last_of_perm, input ready);
    modport sink   (input valid, input picked_value, input last_of_perm, output ready);
endinterface

FILE: rtl/core/rpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpg_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/rpg_mod.sv
// Bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on rpg_pkg.
module rpg_mod #(
    parameter int CW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpg_pkg::RAND_W-1:0] i_dividend,
    input  logic [CW-1:0]              i_divisor,
    output rpg_pkg::t_div_stat         o_stat,
    output logic [CW-1:0]              o_rem
);
    import rpg_pkg::*;

    localparam int NW = $clog2(RAND_W + 1);

    logic [RAND_W-1:0] r_word;
    logic [CW-1:0]     r_rem;
    logic [NW-1:0]     r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [CW:0]       trial;
    logic [CW:0]       diff;

    // shift in the next dividend bit, subtract when it fits
    assign trial = {r_rem, r_word[RAND_W-1]};
    assign diff  = trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(RAND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_word <= {r_word[RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                r_rem <= diff[CW-1:0];
            end else begin
                r_rem <= trial[CW-1:0];
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

FILE: rtl/core/random_permutation_generator.sv
// Random permutation generator (Fisher-Yates shuffle), one element per beat.
// Depends on rpg_pkg, rpg_if, rpg_ram and rpg_mod.
//
// Usage:
//   i_in carries one 31-bit random word per beat; o_res returns one element
//   of the current permutation per input beat, with last_of_perm set on the
//   element that completes it. The next permutation starts straight after.
//   i_cfg_we/i_cfg_data write the permutation length (0 acts as 1, values
//   above MAX_ELEMENTS saturate); a write restarts the permutation.
// Sequence:
//   An accepted item runs through the bit-serial remainder unit (31 random-word
//   bits, one a cycle, then its done strobe), then pool RAM read, pick and
//   write-back, before its result is registered.
//   i_in.ready is high only while idle, so no new beat is accepted until the last one is done.
// Reset:
//   Length returns to 10 and the pool to the identity; no clearing pass is
//   needed as per-entry valid bits make unwritten entries read as their index.
// Stall:
//   The result is held in an output register; the block accepts the next
//   beat meanwhile and only waits before loading if that register is full.
module random_permutation_generator #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    rpg_in_if.sink                    i_in,
    rpg_out_if.source                 o_res,
    input  logic                      i_cfg_we,
    input  logic [rpg_pkg::LEN_W-1:0] i_cfg_data
);
    import rpg_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int LW = (CW > LEN_W) ? CW : LEN_W;

    t_state            r_state;
    t_state            n_state;
    logic [LEN_W-1:0]  r_len;
    logic [CW-1:0]     r_remaining;
    logic [MAX_ELEMENTS-1:0] r_valid;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     r_last;
    logic [AW-1:0]     r_picked;
    logic              r_out_valid;
    logic [PICK_W-1:0] r_out_value;
    logic              r_out_last;

    logic              accept;
    logic              div_start;
    logic              out_free;
    logic              finish;
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_rdata;
    logic [AW-1:0]     last_addr;
    logic [CW-1:0]     div_rem;
    logic [CW-1:0]     eff_cfg;
    logic [CW-1:0]     eff_reset;
    logic              is_last;
    t_div_stat         div_stat;

    function automatic logic [CW-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [CW-1:0] n;
        if (len == '0) begin
            n = CW'(1);
        end else if (LW'(len) > LW'(MAX_ELEMENTS)) begin
            n = CW'(MAX_ELEMENTS);
        end else begin
            n = CW'(len);
        end
        return n;
    endfunction

    assign eff_cfg   = eff_len(i_cfg_data);
    assign eff_reset = eff_len(LEN_RESET);
    assign last_addr = AW'(r_remaining - 1'b1);
    assign is_last   = (r_remaining == CW'(1));
    assign out_free  = !r_out_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_PICK;
            S_PICK: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        ram_raddr  = last_addr;
        finish     = 1'b0;
        case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_RD:   ram_raddr  = r_pos;
            S_DONE: finish     = out_free;
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    assign accept    = i_in.valid && i_in.ready;
    assign div_start = accept;
    assign ram_we    = finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= LEN_RESET;
            r_remaining <= eff_reset;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_len       <= i_cfg_data;
                r_remaining <= eff_cfg;
                r_valid     <= '0;
            end else if (finish) begin
                if (is_last) begin
                    // permutation complete: refill with the identity
                    r_remaining <= eff_len(r_len);
                    r_valid     <= '0;
                end else begin
                    r_remaining <= r_remaining - 1'b1;
                    r_valid[r_pos] <= 1'b1;
                end
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: last live entry, pick position and picked entry
    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_stat.done) begin
            r_pos  <= AW'(div_rem);
            r_last <= r_valid[last_addr] ? ram_rdata : last_addr;
        end
        if (r_state == S_PICK) begin
            r_picked <= r_valid[r_pos] ? ram_rdata : r_pos;
        end
        if (finish) begin
            r_out_value <= PICK_W'(r_picked);
            r_out_last  <= is_last;
        end
    end

    rpg_mod #(
        .CW(CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_in.random_word),
        .i_divisor  (r_remaining),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    rpg_ram #(
        .WIDTH(AW),
        .DEPTH(MAX_ELEMENTS)
    ) u_pool (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_last),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_res.valid        = r_out_valid;
    assign o_res.picked_value = r_out_value;
    assign o_res.last_of_perm = r_out_last;

endmodule
